FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GWT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define GWT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/gwt_pkg.sv
// Shared types, codes and tables of the G-code word tokenizer.
package gwt_pkg;

    localparam int COMMENT_BYTES_DEF = 32;
    localparam int MAX_DIGITS_DEF    = 10;

    localparam int NUM_W       = 34;
    localparam int CLEN_W      = 5;   // comment length, never above 31
    localparam int STORE_DEPTH = 32;
    localparam int QUEUE_DEPTH = 4;   // power of two
    localparam int FRAC_PLACES = 10;

    // Character classes
    localparam logic [4:0] CL_ARG     = 5'h01;
    localparam logic [4:0] CL_DIGIT   = 5'h02;
    localparam logic [4:0] CL_NEWLINE = 5'h04;
    localparam logic [4:0] CL_TEXT    = 5'h08;
    localparam logic [4:0] CL_SPACE   = 5'h10;

    // Result kinds
    localparam logic [2:0] K_WORD  = 3'd0;
    localparam logic [2:0] K_CBYTE = 3'd1;
    localparam logic [2:0] K_EMPTY = 3'd2;
    localparam logic [2:0] K_LINE  = 3'd3;
    localparam logic [2:0] K_ERROR = 3'd4;

    typedef logic [2:0] aop_t;
    typedef logic [1:0] bop_t;

    // First action of a queued item
    localparam aop_t A_NONE  = 3'd0;
    localparam aop_t A_WORD  = 3'd1;
    localparam aop_t A_ERROR = 3'd2;
    localparam aop_t A_FLUSH = 3'd3;
    localparam aop_t A_STORE = 3'd4;

    // Second action of a queued item
    localparam bop_t B_NONE  = 2'd0;
    localparam bop_t B_LINE  = 2'd1;
    localparam bop_t B_ERROR = 2'd2;

    typedef struct packed {
        aop_t              a_op;
        bop_t              b_op;
        logic [7:0]        letter;
        logic              has_num;
        logic              neg;
        logic [NUM_W-1:0]  whole;
        logic [NUM_W-1:0]  frac;
        logic [7:0]        cbyte;
        logic [CLEN_W-1:0] cidx;    // store index, or length for a flush
    } cmd_t;

    function automatic logic [4:0] char_class(input logic [7:0] b);
        logic [4:0] c;
        unique case (b) inside
            8'h09, 8'h20:                         c = CL_TEXT | CL_SPACE;
            8'h0A, 8'h0D:                         c = CL_NEWLINE;
            8'h21, [8'h23:8'h26], [8'h2B:8'h2F]:  c = CL_TEXT;
            8'h2A:                                c = CL_TEXT | CL_ARG;
            [8'h30:8'h39]:                        c = CL_TEXT | CL_DIGIT;
            [8'h3A:8'h40], 8'h4F, [8'h55:8'h57]:  c = CL_TEXT;
            [8'h5B:8'h60], 8'h65, 8'h6F:          c = CL_TEXT;
            [8'h75:8'h77], [8'h7B:8'h7E]:         c = CL_TEXT;
            [8'h41:8'h4E], [8'h50:8'h54]:         c = CL_TEXT | CL_ARG;
            [8'h58:8'h5A], [8'h61:8'h64]:         c = CL_TEXT | CL_ARG;
            [8'h66:8'h6E], [8'h70:8'h74]:         c = CL_TEXT | CL_ARG;
            [8'h78:8'h7A]:                        c = CL_TEXT | CL_ARG;
            default:                              c = 5'h00;
        endcase
        return c;
    endfunction

    // Weight of the n-th fraction digit, in units of ten to the minus ten
    function automatic logic [NUM_W-1:0] frac_weight(input logic [3:0] n);
        logic [NUM_W-1:0] w;
        unique case (n)
            4'd1:    w = 34'd1000000000;
            4'd2:    w = 34'd100000000;
            4'd3:    w = 34'd10000000;
            4'd4:    w = 34'd1000000;
            4'd5:    w = 34'd100000;
            4'd6:    w = 34'd10000;
            4'd7:    w = 34'd1000;
            4'd8:    w = 34'd100;
            4'd9:    w = 34'd10;
            4'd10:   w = 34'd1;
            default: w = 34'd0;
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/gwt_queue.sv
// Short command queue between the tokenizer front and the result back end.
module gwt_queue
    import gwt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hw/rtl/gwt_front.sv
// Tokenizer front: classifies each text byte and queues the actions it causes.
module gwt_front
    import gwt_pkg::*;
#(
    parameter int COMMENT_BYTES = COMMENT_BYTES_DEF,
    parameter int MAX_DIGITS    = MAX_DIGITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    localparam int TEXT_LIMIT = ((COMMENT_BYTES - 1) < 31) ? (COMMENT_BYTES - 1) : 31;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LETTER = 3'd1;
    localparam logic [2:0] PH_SIGN   = 3'd2;
    localparam logic [2:0] PH_WHOLE  = 3'd3;
    localparam logic [2:0] PH_DOT    = 3'd4;
    localparam logic [2:0] PH_INLINE = 3'd5;
    localparam logic [2:0] PH_ENDING = 3'd6;

    logic [2:0]        phase_reg, phase_next;
    logic [7:0]        letter_reg, letter_next;
    logic              minus_reg, minus_next;
    logic              num_reg, num_next;
    logic [NUM_W-1:0]  whole_reg, whole_next;
    logic [NUM_W-1:0]  frac_reg, frac_next;
    logic [CNT_W-1:0]  wcnt_reg, wcnt_next;
    logic [CNT_W-1:0]  fcnt_reg, fcnt_next;
    logic [CLEN_W-1:0] clen_reg, clen_next;
    logic              run_reg, run_next;

    logic [7:0]        b;
    logic [4:0]        cls;
    logic              is_nl, is_digit;
    logic [3:0]        digit;
    logic [CNT_W-1:0]  fcnt_inc;
    logic [NUM_W-1:0]  frac_add;
    logic              again, run_cur;
    aop_t              a_op;
    bop_t              b_op;
    logic              accept;

    assign b        = s_text_byte;
    assign cls      = char_class(b);
    assign is_nl    = (cls & CL_NEWLINE) != '0;
    assign is_digit = (cls & CL_DIGIT) != '0;
    assign digit    = is_digit ? 4'(b - 8'h30) : 4'd0;
    assign fcnt_inc = fcnt_reg + 1'b1;
    assign accept   = s_valid && s_ready;
    assign s_ready  = !q_full;

    // Weight lookup only matters while the digit index stays within ten places
    assign frac_add = (FRAC_PLACES >= int'(fcnt_inc))
                      ? NUM_W'(digit * frac_weight(4'(fcnt_inc))) : '0;

    always_comb begin
        phase_next  = phase_reg;
        letter_next = letter_reg;
        minus_next  = minus_reg;
        num_next    = num_reg;
        whole_next  = whole_reg;
        frac_next   = frac_reg;
        wcnt_next   = wcnt_reg;
        fcnt_next   = fcnt_reg;
        clen_next   = clen_reg;
        run_cur     = run_reg;
        again       = 1'b0;
        a_op        = A_NONE;
        b_op        = B_NONE;

        if (!is_nl && phase_reg != PH_IDLE) begin
            run_cur = 1'b0;
        end
        run_next = run_cur;

        unique case (phase_reg)
            PH_LETTER, PH_SIGN: begin
                if (phase_reg == PH_LETTER && (b == 8'h2B || b == 8'h2D)) begin
                    minus_next = (b == 8'h2D);
                    phase_next = PH_SIGN;
                end else if (is_digit) begin
                    whole_next = (whole_reg << 3) + (whole_reg << 1) + NUM_W'(digit);
                    wcnt_next  = wcnt_reg + 1'b1;
                    num_next   = 1'b1;
                    phase_next = PH_WHOLE;
                end else if (b == 8'h2E) begin
                    phase_next = PH_DOT;
                end else begin
                    a_op  = (phase_reg == PH_LETTER) ? A_WORD : A_ERROR;
                    again = 1'b1;
                end
            end
            PH_WHOLE, PH_DOT: begin
                if (is_digit) begin
                    if (((phase_reg == PH_WHOLE) ? wcnt_reg : fcnt_reg)
                            >= CNT_W'(MAX_DIGITS)) begin
                        // drop the digit
                        a_op       = A_ERROR;
                        phase_next = PH_IDLE;
                    end else if (phase_reg == PH_WHOLE) begin
                        whole_next = (whole_reg << 3) + (whole_reg << 1) + NUM_W'(digit);
                        wcnt_next  = wcnt_reg + 1'b1;
                        num_next   = 1'b1;
                    end else begin
                        frac_next = frac_reg + frac_add;
                        fcnt_next = fcnt_inc;
                        num_next  = 1'b1;
                    end
                end else if (phase_reg == PH_WHOLE && b == 8'h2E) begin
                    phase_next = PH_DOT;
                end else begin
                    a_op  = num_reg ? A_WORD : A_ERROR;
                    again = 1'b1;
                end
            end
            PH_INLINE, PH_ENDING: begin
                if (phase_reg == PH_INLINE && b == 8'h29) begin
                    a_op       = A_FLUSH;
                    phase_next = PH_IDLE;
                end else if (phase_reg == PH_ENDING && is_nl) begin
                    a_op  = A_FLUSH;
                    again = 1'b1;
                end else if ((cls & CL_TEXT) != '0) begin
                    if (clen_reg >= CLEN_W'(TEXT_LIMIT)) begin
                        a_op       = A_ERROR;
                        phase_next = PH_IDLE;
                    end else begin
                        a_op      = A_STORE;
                        clen_next = clen_reg + 1'b1;
                    end
                end else begin
                    a_op  = A_ERROR;
                    again = 1'b1;
                end
            end
            default: begin
                again = 1'b1;
            end
        endcase

        // Handle the byte as if between tokens
        if (again) begin
            phase_next = PH_IDLE;
            if (is_nl) begin
                run_next = 1'b1;
                b_op     = run_cur ? B_NONE : B_LINE;
            end else begin
                run_next = 1'b0;
                if (b == 8'h00) begin
                    b_op = run_cur ? B_NONE : B_LINE;
                end else if ((cls & CL_ARG) != '0) begin
                    letter_next = b;
                    minus_next  = 1'b0;
                    num_next    = 1'b0;
                    whole_next  = '0;
                    frac_next   = '0;
                    wcnt_next   = '0;
                    fcnt_next   = '0;
                    phase_next  = PH_LETTER;
                end else if (b == 8'h28 || b == 8'h3B) begin
                    clen_next  = '0;
                    phase_next = (b == 8'h28) ? PH_INLINE : PH_ENDING;
                end else if ((cls & CL_SPACE) == '0) begin
                    b_op = B_ERROR;
                end
            end
        end
    end

    always_comb begin
        q_push        = accept && (a_op != A_NONE || b_op != B_NONE);
        q_cmd.a_op    = a_op;
        q_cmd.b_op    = b_op;
        q_cmd.letter  = letter_reg;
        q_cmd.has_num = num_reg;
        q_cmd.neg     = num_reg && minus_reg;
        q_cmd.whole   = num_reg ? whole_reg : '0;
        q_cmd.frac    = num_reg ? frac_reg : '0;
        q_cmd.cbyte   = b;
        q_cmd.cidx    = clen_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            letter_reg <= '0;
            minus_reg  <= 1'b0;
            num_reg    <= 1'b0;
            whole_reg  <= '0;
            frac_reg   <= '0;
            wcnt_reg   <= '0;
            fcnt_reg   <= '0;
            clen_reg   <= '0;
            run_reg    <= 1'b0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            letter_reg <= letter_next;
            minus_reg  <= minus_next;
            num_reg    <= num_next;
            whole_reg  <= whole_next;
            frac_reg   <= frac_next;
            wcnt_reg   <= wcnt_next;
            fcnt_reg   <= fcnt_next;
            clen_reg   <= clen_next;
            run_reg    <= run_next;
        end
    end

endmodule

FILE: hw/rtl/gwt_back.sv
// Result back end: executes queued actions, holds the comment store, drives results.
module gwt_back
    import gwt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  cmd_t             q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_kind,
    output logic [7:0]       m_word_letter,
    output logic             m_has_number,
    output logic             m_is_negative,
    output logic [NUM_W-1:0] m_whole_part,
    output logic [NUM_W-1:0] m_fraction_part,
    output logic [7:0]       m_comment_byte,
    output logic             m_last
);

    logic [7:0]        store_mem [STORE_DEPTH];

    logic              step_reg, step_next;
    logic [CLEN_W-1:0] idx_reg, idx_next;

    logic              m_valid_reg;
    logic [2:0]        m_kind_reg;
    logic [7:0]        m_letter_reg;
    logic              m_has_number_reg;
    logic              m_is_negative_reg;
    logic [NUM_W-1:0]  m_whole_reg;
    logic [NUM_W-1:0]  m_frac_reg;
    logic [7:0]        m_cbyte_reg;
    logic              m_last_reg;

    logic              out_free, in_b, b_empty, done;
    logic              emit, emit_word, emit_cbyte, mem_wr;
    logic [2:0]        kind;
    logic              last;

    assign out_free = !m_valid_reg || m_ready;
    assign in_b     = step_reg || (q_head.a_op == A_NONE);
    assign b_empty  = (q_head.b_op == B_NONE);

    always_comb begin
        step_next  = step_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        emit_word  = 1'b0;
        emit_cbyte = 1'b0;
        mem_wr     = 1'b0;
        kind       = K_ERROR;
        last       = 1'b0;
        done       = 1'b0;

        if (q_valid) begin
            if (!in_b) begin
                unique case (q_head.a_op)
                    A_STORE: begin
                        mem_wr = 1'b1;
                        done   = 1'b1;
                    end
                    A_WORD, A_ERROR: begin
                        if (out_free) begin
                            emit      = 1'b1;
                            emit_word = (q_head.a_op == A_WORD);
                            kind      = (q_head.a_op == A_WORD) ? K_WORD : K_ERROR;
                            last      = b_empty;
                            done      = 1'b1;
                        end
                    end
                    A_FLUSH: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (q_head.cidx == '0) begin
                                kind = K_EMPTY;
                                done = 1'b1;
                            end else begin
                                kind       = K_CBYTE;
                                emit_cbyte = 1'b1;
                                done       = (idx_reg == q_head.cidx - 1'b1);
                                idx_next   = idx_reg + 1'b1;
                            end
                            last = done && b_empty;
                        end
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
                // advance to the second action, or retire the item
                if (done) begin
                    idx_next = '0;
                    if (b_empty) begin
                        q_pop = 1'b1;
                    end else begin
                        step_next = 1'b1;
                    end
                end
            end else if (b_empty) begin
                q_pop     = 1'b1;
                step_next = 1'b0;
            end else if (out_free) begin
                emit      = 1'b1;
                kind      = (q_head.b_op == B_LINE) ? K_LINE : K_ERROR;
                last      = 1'b1;
                q_pop     = 1'b1;
                step_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            idx_reg  <= idx_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Comment store: written by store actions, read during a flush
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            store_mem[q_head.cidx] <= q_head.cbyte;
        end
        if (emit) begin
            m_cbyte_reg <= emit_cbyte ? store_mem[idx_reg] : 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_kind_reg        <= kind;
            m_letter_reg      <= emit_word ? q_head.letter : 8'h00;
            m_has_number_reg  <= emit_word && q_head.has_num;
            m_is_negative_reg <= emit_word && q_head.neg;
            m_whole_reg       <= emit_word ? q_head.whole : '0;
            m_frac_reg        <= emit_word ? q_head.frac : '0;
            m_last_reg        <= last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_word_letter   = m_letter_reg;
    assign m_has_number    = m_has_number_reg;
    assign m_is_negative   = m_is_negative_reg;
    assign m_whole_part    = m_whole_reg;
    assign m_fraction_part = m_frac_reg;
    assign m_comment_byte  = m_cbyte_reg;
    assign m_last          = m_last_reg;

endmodule

FILE: hw/rtl/gcode_word_tokenizer_top.sv
// Top level of the G-code word tokenizer.
//
// Input channel (s_*): one text byte per item, valid/ready. A zero byte marks end of text.
// Result channel (m_*): one result per item: argument word, comment byte, empty comment,
// line end or error; m_last marks the final result caused by one input byte.
// Fields that do not belong to a result's kind read as zero.
//
// A taken byte's actions pass through the command queue, and its results through the result register.
// The front takes one byte per cycle while the queue has room. A byte can cause two results;
// a closed comment is sent one byte per cycle from the comment store while the receiver is
// ready. The four-entry command queue between the front and the back end absorbs these
// bursts; once it fills, s_ready drops until the back end drains.
//
// When the receiver stalls, the result register holds its item and the back end stops at
// its next result; the front keeps taking bytes until the queue is full.
// Reset (aresetn low, synchronous) returns to between tokens, empties the queue and
// drops any pending result. The comment store needs no clearing.
module gcode_word_tokenizer_top
    import gwt_pkg::*;
#(
    parameter int COMMENT_BYTES = COMMENT_BYTES_DEF,
    parameter int MAX_DIGITS    = MAX_DIGITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_text_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_kind,
    output logic [7:0]       m_word_letter,
    output logic             m_has_number,
    output logic             m_is_negative,
    output logic [NUM_W-1:0] m_whole_part,
    output logic [NUM_W-1:0] m_fraction_part,
    output logic [7:0]       m_comment_byte,
    output logic             m_last
);

    logic q_push, q_full, q_pop, q_valid;
    cmd_t q_cmd, q_head;

    gwt_front #(
        .COMMENT_BYTES (COMMENT_BYTES),
        .MAX_DIGITS    (MAX_DIGITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    gwt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    gwt_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_word_letter   (m_word_letter),
        .m_has_number    (m_has_number),
        .m_is_negative   (m_is_negative),
        .m_whole_part    (m_whole_part),
        .m_fraction_part (m_fraction_part),
        .m_comment_byte  (m_comment_byte),
        .m_last          (m_last)
    );

endmodule

FILE: hw/rtl/gwt_checker.sv
// Port-level checks of the G-code word tokenizer, bound to its top level.
`include "assert_macros.svh"

module gwt_checker
    import gwt_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic [7:0]       s_text_byte,
    input logic             m_valid,
    input logic             m_ready,
    input logic [2:0]       m_kind,
    input logic [7:0]       m_word_letter,
    input logic             m_has_number,
    input logic             m_is_negative,
    input logic [NUM_W-1:0] m_whole_part,
    input logic [NUM_W-1:0] m_fraction_part,
    input logic [7:0]       m_comment_byte,
    input logic             m_last
);

    // A stalled result holds its payload
    `GWT_ASSERT(a_stall_hold, m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_last) && $stable(m_comment_byte), "result changed while stalled")

    // Word fields stay zero on any other kind
    `GWT_ASSERT(a_word_fields_zero, m_valid && m_kind != K_WORD |-> m_word_letter == 8'h00 && !m_has_number && m_whole_part == '0 && m_fraction_part == '0, "word fields set on a non-word result")

    // A sign only comes with a number
    `GWT_ASSERT(a_sign_needs_number, m_valid && m_is_negative |-> m_has_number, "negative flag without a number")

    // Comment bytes only on comment-byte results
    `GWT_ASSERT(a_cbyte_zero, m_valid && m_kind != K_CBYTE |-> m_comment_byte == 8'h00, "comment byte set on another kind")

    // Reset drops any pending result
    `GWT_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind gcode_word_tokenizer_top gwt_checker u_gwt_checker (.*);
